// ===== rtl/rmoa_pkg.sv =====
// Types, codes and constants shared by the robot mode and obstacle avoid block.
`timescale 1ns / 1ps
package rmoa_pkg;

  localparam int unsigned TickW  = 32;
  localparam int unsigned CmdW   = 4;
  localparam int unsigned DistW  = 16;
  localparam int unsigned SpeedW = 16;
  localparam int unsigned SafeW  = 10;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned ActW   = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Reset values of the configuration registers
  localparam logic [SpeedW-1:0] MaxSpeedRst = 16'd1000;
  localparam logic [SafeW-1:0]  SafeDistRst = 10'd25;
  localparam logic [TimeW-1:0]  PollRst     = 16'd50;
  localparam logic [TimeW-1:0]  PauseRst    = 16'd300;
  localparam logic [TimeW-1:0]  TurnRst     = 16'd350;
  localparam logic [SpeedW-1:0] Speed70Rst  = 16'd700;
  localparam logic [SpeedW-1:0] Speed60Rst  = 16'd600;

  // 70 % = 7x / 10 and 60 % = 3x / 5, both through reciprocal multiplication
  localparam int unsigned Div10ArgW = SpeedW + 3;
  localparam int unsigned Div10Sh   = 23;
  localparam logic [19:0] Div10Mul  = 20'd838861;
  localparam int unsigned Div5ArgW  = SpeedW + 2;
  localparam int unsigned Div5Sh    = 21;
  localparam logic [18:0] Div5Mul   = 19'd419431;

  typedef enum logic [CmdW-1:0] {
    CMD_NONE   = 4'd0,
    CMD_REMOTE = 4'd1,
    CMD_AVOID  = 4'd2,
    CMD_LINE   = 4'd3,
    CMD_IDLE   = 4'd4,
    CMD_UP     = 4'd5,
    CMD_DOWN   = 4'd6,
    CMD_LEFT   = 4'd7,
    CMD_RIGHT  = 4'd8
  } cmd_e;

  typedef enum logic [ActW-1:0] {
    ACT_NONE  = 3'd0,
    ACT_STOP  = 3'd1,
    ACT_FWD   = 3'd2,
    ACT_BACK  = 3'd3,
    ACT_LEFT  = 3'd4,
    ACT_RIGHT = 3'd5
  } act_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_REMOTE = 2'd1,
    MODE_AVOID  = 2'd2,
    MODE_LINE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PH_FWD   = 2'd0,
    PH_STOP1 = 2'd1,
    PH_TURN  = 2'd2,
    PH_STOP2 = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_SPEED = 3'd0,
    REG_SAFE_DIST = 3'd1,
    REG_POLL      = 3'd2,
    REG_PAUSE     = 3'd3,
    REG_TURN      = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [TickW-1:0] tick_ms;
    logic [CmdW-1:0]  ir_command;
    logic [DistW-1:0] distance_cm;
  } in_item_t;

  typedef struct packed {
    logic [ActW-1:0]   motor_action;
    logic [SpeedW-1:0] motor_speed;
    logic [1:0]        robot_mode;
    logic [1:0]        avoid_phase;
  } out_item_t;

  typedef struct packed {
    mode_e            mode;
    phase_e           phase;
    logic [TickW-1:0] start_tick;
  } state_t;

  // Settings as the step logic sees them, speeds already scaled
  typedef struct packed {
    logic [SpeedW-1:0] speed70;
    logic [SpeedW-1:0] speed60;
    logic [SpeedW-1:0] speed50;
    logic [SafeW-1:0]  safe_dist;
    logic [TimeW-1:0]  poll;
    logic [TimeW-1:0]  pause;
    logic [TimeW-1:0]  turn;
  } cfg_t;

endpackage

// ===== rtl/rmoa_if.sv =====
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps
interface rmoa_in_if;
  logic                        valid;
  logic                        ready;
  logic [rmoa_pkg::TickW-1:0]  tick_ms;
  logic [rmoa_pkg::CmdW-1:0]   ir_command;
  logic [rmoa_pkg::DistW-1:0]  distance_cm;

  modport source (output valid, tick_ms, ir_command, distance_cm, input ready);
  modport sink   (input valid, tick_ms, ir_command, distance_cm, output ready);
endinterface

interface rmoa_out_if;
  logic                        valid;
  logic                        ready;
  logic [rmoa_pkg::ActW-1:0]   motor_action;
  logic [rmoa_pkg::SpeedW-1:0] motor_speed;
  logic [1:0]                  robot_mode;
  logic [1:0]                  avoid_phase;

  modport source (output valid, motor_action, motor_speed, robot_mode, avoid_phase,
                  input ready);
  modport sink   (input valid, motor_action, motor_speed, robot_mode, avoid_phase,
                  output ready);
endinterface

// ===== rtl/rmoa_cfg.sv =====
// Configuration registers and the registered percentage speed table.
`timescale 1ns / 1ps
module rmoa_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rmoa_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rmoa_pkg::CfgDataW-1:0]  cfg_data_i,
  output rmoa_pkg::cfg_t                 cfg_o
);

  logic [rmoa_pkg::SpeedW-1:0] max_speed_q;
  logic [rmoa_pkg::SafeW-1:0]  safe_q;
  logic [rmoa_pkg::TimeW-1:0]  poll_q, pause_q, turn_q;
  logic [rmoa_pkg::SpeedW-1:0] speed70_q, speed60_q;
  logic [rmoa_pkg::SpeedW-1:0] speed70_d, speed60_d;

  logic [rmoa_pkg::Div10ArgW-1:0] x7;
  logic [rmoa_pkg::Div5ArgW-1:0]  x3;
  logic [rmoa_pkg::Div10ArgW+19:0] p7;
  logic [rmoa_pkg::Div5ArgW+18:0]  p3;

  // Load the scaled speeds together with max_speed so all speed settings move at the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= rmoa_pkg::MaxSpeedRst;
      safe_q      <= rmoa_pkg::SafeDistRst;
      poll_q      <= rmoa_pkg::PollRst;
      pause_q     <= rmoa_pkg::PauseRst;
      turn_q      <= rmoa_pkg::TurnRst;
      speed70_q   <= rmoa_pkg::Speed70Rst;
      speed60_q   <= rmoa_pkg::Speed60Rst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rmoa_pkg::REG_MAX_SPEED: begin
          max_speed_q <= cfg_data_i;
          speed70_q   <= speed70_d;
          speed60_q   <= speed60_d;
        end
        rmoa_pkg::REG_SAFE_DIST: safe_q      <= cfg_data_i[rmoa_pkg::SafeW-1:0];
        rmoa_pkg::REG_POLL:      poll_q      <= cfg_data_i;
        rmoa_pkg::REG_PAUSE:     pause_q     <= cfg_data_i;
        rmoa_pkg::REG_TURN:      turn_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // 7x / 10 and 3x / 5 of the incoming max_speed; the reciprocals are exact
  // over the full 16-bit range
  always_comb begin
    x7 = ({3'b000, cfg_data_i} << 3) - {3'b000, cfg_data_i};
    x3 = ({2'b00, cfg_data_i} << 1) + {2'b00, cfg_data_i};
    p7 = {20'd0, x7} * {{rmoa_pkg::Div10ArgW{1'b0}}, rmoa_pkg::Div10Mul};
    p3 = {19'd0, x3} * {{rmoa_pkg::Div5ArgW{1'b0}}, rmoa_pkg::Div5Mul};
    speed70_d = p7[rmoa_pkg::Div10Sh +: rmoa_pkg::SpeedW];
    speed60_d = p3[rmoa_pkg::Div5Sh +: rmoa_pkg::SpeedW];
  end

  assign cfg_o.speed70   = speed70_q;
  assign cfg_o.speed60   = speed60_q;
  assign cfg_o.speed50   = max_speed_q >> 1;
  assign cfg_o.safe_dist = safe_q;
  assign cfg_o.poll      = poll_q;
  assign cfg_o.pause     = pause_q;
  assign cfg_o.turn      = turn_q;

endmodule

// ===== rtl/rmoa_step.sv =====
// Next-state and result logic for one control-loop pass.
`timescale 1ns / 1ps
module rmoa_step (
  input  rmoa_pkg::in_item_t  item_i,
  input  rmoa_pkg::state_t    state_i,
  input  rmoa_pkg::cfg_t      cfg_i,
  output rmoa_pkg::state_t    state_o,
  output rmoa_pkg::out_item_t res_o
);

  rmoa_pkg::act_e              act;
  logic [rmoa_pkg::SpeedW-1:0] spd;
  rmoa_pkg::state_t            st;
  logic                        remote;
  logic [rmoa_pkg::TickW-1:0]  elapsed;
  logic                        near;

  always_comb begin
    act    = rmoa_pkg::ACT_NONE;
    spd    = '0;
    st     = state_i;
    remote = (state_i.mode == rmoa_pkg::MODE_REMOTE);

    case (item_i.ir_command)
      rmoa_pkg::CMD_REMOTE: begin
        st.mode = rmoa_pkg::MODE_REMOTE;
        act     = rmoa_pkg::ACT_STOP;
      end
      rmoa_pkg::CMD_AVOID: begin
        st.mode       = rmoa_pkg::MODE_AVOID;
        st.phase      = rmoa_pkg::PH_FWD;
        st.start_tick = item_i.tick_ms;
        act           = rmoa_pkg::ACT_STOP;
      end
      rmoa_pkg::CMD_LINE: begin
        st.mode = rmoa_pkg::MODE_LINE;
        act     = rmoa_pkg::ACT_STOP;
      end
      rmoa_pkg::CMD_IDLE: begin
        st.mode = rmoa_pkg::MODE_IDLE;
        act     = rmoa_pkg::ACT_STOP;
      end
      rmoa_pkg::CMD_UP: if (remote) begin
        act = rmoa_pkg::ACT_FWD;
        spd = cfg_i.speed70;
      end
      rmoa_pkg::CMD_DOWN: if (remote) begin
        act = rmoa_pkg::ACT_BACK;
        spd = cfg_i.speed70;
      end
      rmoa_pkg::CMD_LEFT: if (remote) begin
        act = rmoa_pkg::ACT_LEFT;
        spd = cfg_i.speed60;
      end
      rmoa_pkg::CMD_RIGHT: if (remote) begin
        act = rmoa_pkg::ACT_RIGHT;
        spd = cfg_i.speed60;
      end
      default: ;
    endcase

    // Tick difference wraps modulo 2^32
    elapsed = item_i.tick_ms - st.start_tick;
    near    = (item_i.distance_cm != '0) &&
              (item_i.distance_cm < {{(rmoa_pkg::DistW-rmoa_pkg::SafeW){1'b0}},
                                     cfg_i.safe_dist});

    if (st.mode == rmoa_pkg::MODE_AVOID) begin
      case (st.phase)
        rmoa_pkg::PH_FWD: begin
          if (elapsed > {16'd0, cfg_i.poll}) begin
            st.start_tick = item_i.tick_ms;
            if (near) begin
              act      = rmoa_pkg::ACT_STOP;
              spd      = '0;
              st.phase = rmoa_pkg::PH_STOP1;
            end else begin
              act = rmoa_pkg::ACT_FWD;
              spd = cfg_i.speed50;
            end
          end
        end
        rmoa_pkg::PH_STOP1: begin
          if (elapsed > {16'd0, cfg_i.pause}) begin
            act           = rmoa_pkg::ACT_RIGHT;
            spd           = cfg_i.speed50;
            st.phase      = rmoa_pkg::PH_TURN;
            st.start_tick = item_i.tick_ms;
          end
        end
        rmoa_pkg::PH_TURN: begin
          if (elapsed > {16'd0, cfg_i.turn}) begin
            act           = rmoa_pkg::ACT_STOP;
            spd           = '0;
            st.phase      = rmoa_pkg::PH_STOP2;
            st.start_tick = item_i.tick_ms;
          end
        end
        default: begin
          if (elapsed > {16'd0, cfg_i.pause}) begin
            st.phase      = rmoa_pkg::PH_FWD;
            st.start_tick = item_i.tick_ms;
          end
        end
      endcase
    end
  end

  assign state_o            = st;
  assign res_o.motor_action = act;
  assign res_o.motor_speed  = spd;
  assign res_o.robot_mode   = st.mode;
  assign res_o.avoid_phase  = st.phase;

endmodule

// ===== rtl/robot_mode_and_obstacle_avoid.sv =====
// Top level: robot mode controller with timed obstacle avoidance.
// Path: an accepted item goes into the input register and then into the result register,
// where it can be taken; a full result register that is not drained holds it back.
// Throughput: one item per cycle while the output is ready; the only loop is the
// mode/phase/timer state, updated in the same cycle as the result register.
// Reset (rst_ni low, asynchronous): idle mode, forward phase, timer start 0,
// all settings back to their defaults, both pipeline registers empty.
`timescale 1ns / 1ps
module robot_mode_and_obstacle_avoid (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rmoa_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rmoa_pkg::CfgDataW-1:0]  cfg_data_i,
  rmoa_in_if.sink                        in_i,
  rmoa_out_if.source                     out_o
);

  rmoa_pkg::cfg_t      cfg;
  rmoa_pkg::in_item_t  in_q;
  logic                in_vld_q;
  rmoa_pkg::out_item_t out_q;
  logic                out_vld_q;
  rmoa_pkg::state_t    state_q, state_d;
  rmoa_pkg::out_item_t res_d;
  logic                advance;
  logic                in_take;

  // Settings; the scaled speed table is loaded at the same edge as max_speed,
  // so the speed settings all take effect together.
  rmoa_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Combinational pass from the input register and current state
  rmoa_step u_step (
    .item_i  (in_q),
    .state_i (state_q),
    .cfg_i   (cfg),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // Advance the held item when the result register is empty or being drained
  assign advance     = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || advance;
  assign in_take     = in_i.valid && in_i.ready;

  // Control: valid flags and the robot state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '{mode: rmoa_pkg::MODE_IDLE, phase: rmoa_pkg::PH_FWD,
                     start_tick: '0};
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload: capture the item on accept, hold the result until taken
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.tick_ms     <= in_i.tick_ms;
      in_q.ir_command  <= in_i.ir_command;
      in_q.distance_cm <= in_i.distance_cm;
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.motor_action = out_q.motor_action;
  assign out_o.motor_speed  = out_q.motor_speed;
  assign out_o.robot_mode   = out_q.robot_mode;
  assign out_o.avoid_phase  = out_q.avoid_phase;

endmodule
